### hw/rtl/ssf_pkg.sv
// Shared types, widths and codes for the sweeping scanner stepper and framer.
// Used by the channel interfaces and the front, queue, back and top modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssf_pkg;

  localparam int unsigned POS_W     = 7;
  localparam int unsigned COIL_W    = 4;
  localparam int unsigned ECHO_W    = 8;
  localparam int unsigned RANGE_W   = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FRAME_LEN = 4;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  localparam logic [POS_W-1:0] SWEEP_LIMIT_RESET = 7'd72;

  // Depth of the job queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_CAPTURE = 2'd1,
    ACT_SAMPLE  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  localparam logic KIND_COIL  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // One unit of work for the back: a coil report or a whole frame.
  typedef struct packed {
    logic                             is_frame;
    logic [COIL_W-1:0]                coils;
    logic                             trig;
    logic [FRAME_LEN-1:0][BYTE_W-1:0] frame;
  } job_t;

  // Coil drive toggled by each motor phase.
  function automatic logic [COIL_W-1:0] phase_coil(input logic [2:0] phase);
    logic [COIL_W-1:0] mask;
    unique case (phase)
      3'd0, 3'd3: mask = 4'b0001;
      3'd4, 3'd7: mask = 4'b0010;
      3'd1, 3'd6: mask = 4'b0100;
      3'd2, 3'd5: mask = 4'b1000;
      default:    mask = 4'b0000;
    endcase
    return mask;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ssf_channels.sv
// Valid/ready channel interfaces for the scanner block: commands, results, configuration.
// Depends on ssf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ssf_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic                         echo_pin_high;
  logic [ssf_pkg::ECHO_W-1:0]   echo_count;
  logic [ssf_pkg::RANGE_W-1:0]  range_sample;

  modport source(output valid, action, echo_pin_high, echo_count, range_sample,
                 input ready);
  modport sink(input valid, action, echo_pin_high, echo_count, range_sample,
               output ready);
endinterface

interface ssf_res_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ssf_pkg::COIL_W-1:0]  coils;
  logic                        trigger_level;
  logic [ssf_pkg::BYTE_W-1:0]  frame_byte;
  logic                        last;

  modport source(output valid, kind, coils, trigger_level, frame_byte, last,
                 input ready);
  modport sink(input valid, kind, coils, trigger_level, frame_byte, last,
               output ready);
endinterface

interface ssf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ssf_pkg::POS_W-1:0]  data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ssf_front.sv
// Front of the scanner: takes commands, updates motor, echo and trigger state,
// and pushes coil and frame jobs to the queue. Depends on ssf_pkg and ssf_channels.
`timescale 1ns / 1ps
`default_nettype none

module ssf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  ssf_cmd_if.sink            cmd,
  ssf_cfg_if.sink            cfg,
  input  wire logic          q_full,
  output ssf_pkg::job_t      push_job,
  output logic               push
);

  logic [ssf_pkg::POS_W-1:0]  sweep_limit;
  logic [ssf_pkg::POS_W-1:0]  position, position_next;
  logic                       moving_down, moving_down_next;
  logic [ssf_pkg::COIL_W-1:0] coil_levels, coil_levels_next;
  logic                       trigger_state, trigger_state_next;
  logic [ssf_pkg::ECHO_W-1:0] echo_value, echo_value_next;

  logic [ssf_pkg::POS_W-1:0] step_pos;
  logic [2:0]                phase;
  logic [ssf_pkg::COIL_W-1:0] tick_coils;
  logic                      tick_down;
  logic                      accept;

  assign cmd.ready = !q_full;
  assign cfg.ready = 1'b1;
  assign accept    = cmd.valid && cmd.ready;

  // Motor step: move one position toward the current end of the sweep.
  always_comb begin
    step_pos = position;
    if (!moving_down && (position < sweep_limit)) begin
      step_pos = position + 7'd1;
    end
    if (moving_down && (position != '0)) begin
      step_pos = position - 7'd1;
    end
    phase      = moving_down ? (step_pos[2:0] + 3'd1) : step_pos[2:0];
    tick_coils = coil_levels ^ ssf_pkg::phase_coil(phase);
    tick_down  = moving_down;
    if (step_pos >= sweep_limit) begin
      tick_down = 1'b1;
    end
    if (step_pos == '0) begin
      tick_down = 1'b0;
    end
  end

  always_comb begin
    position_next      = position;
    moving_down_next   = moving_down;
    coil_levels_next   = coil_levels;
    trigger_state_next = trigger_state;
    echo_value_next    = echo_value;
    push               = 1'b0;
    unique case (cmd.action)
      ssf_pkg::ACT_TICK: begin
        position_next    = step_pos;
        moving_down_next = tick_down;
        coil_levels_next = tick_coils;
        push             = accept;
      end
      ssf_pkg::ACT_CAPTURE: begin
        if (!cmd.echo_pin_high) begin
          echo_value_next = cmd.echo_count;
        end
      end
      ssf_pkg::ACT_SAMPLE: begin
        trigger_state_next = !trigger_state;
        push               = accept;
      end
      ssf_pkg::ACT_NONE: begin
      end
    endcase
  end

  // The job snapshots the state as it stands after this command.
  always_comb begin
    push_job.is_frame = (cmd.action == ssf_pkg::ACT_SAMPLE);
    push_job.coils    = coil_levels_next;
    push_job.trig     = trigger_state_next;
    push_job.frame[0] = {1'b0, position};
    push_job.frame[1] = {2'b10, echo_value[7:2]};
    push_job.frame[2] = {1'b1, echo_value[1:0], cmd.range_sample[15:11]};
    push_job.frame[3] = {1'b1, cmd.range_sample[10:4]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_limit   <= ssf_pkg::SWEEP_LIMIT_RESET;
      position      <= '0;
      moving_down   <= 1'b0;
      coil_levels   <= '0;
      trigger_state <= 1'b0;
      echo_value    <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        sweep_limit <= cfg.data;
      end
      if (accept) begin
        position      <= position_next;
        moving_down   <= moving_down_next;
        coil_levels   <= coil_levels_next;
        trigger_state <= trigger_state_next;
        echo_value    <= echo_value_next;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ssf_queue.sv
// Small first-in first-out job queue between the front and the back of the scanner.
// Depends on ssf_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module ssf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ssf_pkg::job_t  push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output ssf_pkg::job_t       head_job
);

  ssf_pkg::job_t                entries [ssf_pkg::QUEUE_DEPTH];
  logic [ssf_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [ssf_pkg::QCNT_W-1:0]   count;
  logic                         do_push, do_pop;

  localparam logic [ssf_pkg::QPTR_W-1:0] PTR_LAST = ssf_pkg::QPTR_W'(ssf_pkg::QUEUE_DEPTH - 1);
  localparam logic [ssf_pkg::QCNT_W-1:0] CNT_FULL = ssf_pkg::QCNT_W'(ssf_pkg::QUEUE_DEPTH);

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ssf_back.sv
// Back of the scanner: holds one job and sends it as one coil report or four frame bytes.
// Depends on ssf_pkg and ssf_channels.
`timescale 1ns / 1ps
`default_nettype none

module ssf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire ssf_pkg::job_t head_job,
  output logic               pop,
  ssf_res_if.source          res
);

  localparam logic [ssf_pkg::IDX_W-1:0] IDX_LAST = ssf_pkg::IDX_W'(ssf_pkg::FRAME_LEN - 1);

  ssf_pkg::job_t              job;
  logic                       busy;
  logic [ssf_pkg::IDX_W-1:0]  idx;
  logic                       is_last;
  logic                       sent;

  assign is_last = !job.is_frame || (idx == IDX_LAST);
  assign sent    = res.valid && res.ready;
  assign pop     = head_valid && (!busy || (sent && is_last));

  assign res.valid         = busy;
  assign res.kind          = job.is_frame ? ssf_pkg::KIND_FRAME : ssf_pkg::KIND_COIL;
  assign res.coils         = job.coils;
  assign res.trigger_level = job.trig;
  assign res.frame_byte    = job.is_frame ? job.frame[idx] : '0;
  assign res.last          = is_last;

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (sent) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/scanning_sensor_stepper_and_framer.sv
// Top level of the sweeping range scanner controller.
// Depends on ssf_pkg, ssf_channels, ssf_front, ssf_queue and ssf_back.
//
// Usage:
//   The cmd channel carries events: a motor tick, an echo capture or a range
//   sample. A tick moves the sweep position one step and yields one coil
//   report on the res channel. A capture stores the echo count (unless the
//   pin is high) and yields nothing. A sample toggles the trigger and yields
//   four frame bytes, the last one flagged. Each result carries the coil and
//   trigger levels as they stood right after its event.
//   The cfg channel writes the sweep limit; it is always ready and should be
//   used only while no results are pending.
//   A command is written into the job queue and then popped into the back's
//   job register, which drives res. The front accepts one command per cycle
//   as long as the four-entry job queue has room; the back sends one result
//   per cycle while the receiver is ready. The back is the rate setter, since
//   a sample yields four results and a tick only one.
//   When the receiver stalls, the current result holds, the queue fills and
//   cmd.ready drops once it is full; captures also wait in that case.
//   Synchronous reset restores the limit to 72, clears position, direction,
//   coils, trigger and echo, and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module scanning_sensor_stepper_and_framer (
  input  wire logic   clk,
  input  wire logic   rst,
  ssf_cmd_if.sink     cmd,
  ssf_res_if.source   res,
  ssf_cfg_if.sink     cfg
);

  ssf_pkg::job_t push_job;
  ssf_pkg::job_t head_job;
  logic          push;
  logic          q_full;
  logic          head_valid;
  logic          pop;

  // Front: state updates happen at the command transfer itself.
  ssf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .q_full   (q_full),
    .push_job (push_job),
    .push     (push)
  );

  // Queue decouples command intake from result delivery.
  ssf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: serializes each job into its results.
  ssf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .res        (res)
  );

endmodule

`default_nettype wire

### hw/rtl/ssf_checker.sv
// Port-level checks for the scanner block, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none

module ssf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       res_kind,
  input wire logic       res_last,
  input wire logic [7:0] res_frame_byte
);

  // A stalled result stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered after reset");

  // A coil report is a single result with a zero byte.
  a_coil_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_kind |-> res_last && (res_frame_byte == 8'd0))
    else $error("malformed coil report");

  // Frame bytes follow one another without a gap or a foreign result.
  a_frame_cont: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_kind && !res_last |=> res_valid && res_kind)
    else $error("frame interrupted");

  // Only the position byte has bit 7 clear, and it never ends a frame.
  a_frame_first: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind && !res_frame_byte[7] |-> !res_last)
    else $error("frame ends on position byte");

endmodule

bind scanning_sensor_stepper_and_framer ssf_checker u_ssf_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_kind       (res.kind),
  .res_last       (res.last),
  .res_frame_byte (res.frame_byte)
);

`default_nettype wire
